// ===== rtl/ehfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Ethernet header field extractor package
// Shared codes, header constants, the frame record that passes from the
// capture stage to the result stage, and the result item type.
// ----------------------------------------------------------------------------
package ehfe_pkg;

    // Frame kind codes.
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_IPV4  = 2'd1;
    localparam logic [1:0] KIND_IPV6  = 2'd2;
    localparam logic [1:0] KIND_ARP   = 2'd3;

    // Status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNKNOWN   = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    // Ethertypes.
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;

    // IP protocol numbers of interest.
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IGMP = 8'd2;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Offset of the first byte after the Ethernet header.
    localparam int ETH_HDR_BYTES = 14;

    // Stream widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 408;
    localparam int M_TUSER_W = 4;

    // Everything collected from one frame, handed over at its last byte.
    typedef struct packed {
        logic [15:0] len;
        logic [15:0] ethertype;
        logic [5:0]  ihl_bytes;
        logic [7:0]  proto;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [31:0] ports;
    } frame_rec_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [1:0]  status;
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [63:0] source_ip_high;
        logic [63:0] source_ip_low;
        logic [63:0] dest_ip_high;
        logic [63:0] dest_ip_low;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        ports_valid;
        logic [15:0] frame_length;
    } result_t;

    // Map an ethertype onto a frame kind.
    function automatic logic [1:0] kind_of(input logic [15:0] etype);
        logic [1:0] kind;
        unique case (etype)
            ETYPE_IPV4: kind = KIND_IPV4;
            ETYPE_IPV6: kind = KIND_IPV6;
            ETYPE_ARP:  kind = KIND_ARP;
            default:    kind = KIND_OTHER;
        endcase
        return kind;
    endfunction

endpackage

// ===== rtl/ethernet_header_field_extractor.sv =====
// ----------------------------------------------------------------------------
// Ethernet header field extractor
// Takes an Ethernet frame one byte per item and gives one result item per
// frame with MAC addresses, frame kind, IP addresses, ports and length.
// ----------------------------------------------------------------------------
// The block takes one frame byte per clock with no gaps required, and each
// frame gives exactly one result item on the master side. The path is an
// input register, the capture stage that places each byte by its position in
// the frame, a frame record register and the output register; a frame's
// record can wait behind an unread result while the next frame's bytes keep
// flowing, and input stalls only when a last byte arrives with both the record
// and the output register still full. Frame length counts up to 2^LEN_WIDTH-1
// and then holds.
module ethernet_header_field_extractor #(
    parameter int LEN_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: data_byte[7:0]
    input  logic [ehfe_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // m_tdata: dest_mac[47:0], source_mac[95:48], source_ip_high[159:96],
    // source_ip_low[223:160], dest_ip_high[287:224], dest_ip_low[351:288],
    // source_port[367:352], dest_port[383:368], ports_valid[384],
    // frame_length[400:385], zero fill[407:401]
    output logic [ehfe_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: frame_kind[1:0], status[3:2]
    output logic [ehfe_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import ehfe_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_take;
    logic       s_accept;
    logic       rec_valid, rec_pop;
    frame_rec_t rec;
    result_t    out_item;

    // Input register: refills in the same cycle it drains.
    assign s_tready      = !in_valid_reg || in_take;
    assign s_accept      = s_tvalid && s_tready;
    assign in_valid_next = s_accept ? 1'b1 : (in_take ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Byte placement and frame record.
    ehfe_capture #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_capture (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .in_take   (in_take),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_pop   (rec_pop)
    );

    // Classification and output register.
    ehfe_result u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_pop   (rec_pop),
        .out_valid (m_tvalid),
        .out_item  (out_item),
        .out_ready (m_tready)
    );

    // Pack the result item onto the master side.
    assign m_tuser = {out_item.status, out_item.frame_kind};
    assign m_tdata = {7'd0,
                      out_item.frame_length,
                      out_item.ports_valid,
                      out_item.dest_port,
                      out_item.source_port,
                      out_item.dest_ip_low,
                      out_item.dest_ip_high,
                      out_item.source_ip_low,
                      out_item.source_ip_high,
                      out_item.source_mac,
                      out_item.dest_mac};

endmodule

// ===== rtl/ehfe_capture.sv =====
// ----------------------------------------------------------------------------
// Ethernet header field extractor: capture stage
// Counts bytes of the current frame and drops each byte into its header field
// by position compare. At the last byte the collected fields move into a
// frame record register and the accumulators clear for the next frame.
// ----------------------------------------------------------------------------
module ehfe_capture #(
    parameter int LEN_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                in_take,
    output logic                rec_valid,
    output ehfe_pkg::frame_rec_t rec,
    input  logic                rec_pop
);
    import ehfe_pkg::*;

    localparam logic [LEN_WIDTH-1:0] LEN_MAX  = '1;
    localparam logic [LEN_WIDTH-1:0] POS_HDR  = LEN_WIDTH'(ETH_HDR_BYTES);
    localparam logic [LEN_WIDTH-1:0] POS_IHL  = LEN_WIDTH'(14);
    localparam logic [LEN_WIDTH-1:0] POS_P4   = LEN_WIDTH'(23);
    localparam logic [LEN_WIDTH-1:0] POS_P6   = LEN_WIDTH'(20);

    logic [LEN_WIDTH-1:0] count_reg, count_next, count_inc;
    logic [47:0]          dst_mac_reg, dst_mac_next;
    logic [47:0]          src_mac_reg, src_mac_next;
    logic [15:0]          ethertype_reg, ethertype_next;
    logic [5:0]           ihl_reg, ihl_next;
    logic [7:0]           proto_reg, proto_next;
    logic [63:0]          src_hi_reg, src_hi_next;
    logic [63:0]          src_lo_reg, src_lo_next;
    logic [63:0]          dst_hi_reg, dst_hi_next;
    logic [63:0]          dst_lo_reg, dst_lo_next;
    logic [31:0]          ports_reg, ports_next;
    logic                 rec_valid_reg, rec_valid_next;
    frame_rec_t           rec_reg;

    logic [LEN_WIDTH-1:0] pos;
    logic                 in_payload;
    logic                 is_v4, is_v6, is_arp;
    logic [5:0]           hdr;
    logic [6:0]           l4_start;
    logic [LEN_WIDTH-1:0] l4_pos, port_off;
    logic                 port_hit;

    // A last byte may only enter once the record register has room.
    assign in_take = in_valid && (!in_last || !rec_valid_reg || rec_pop);

    // Saturating byte counter.
    assign pos       = count_reg;
    assign count_inc = (count_reg == LEN_MAX) ? count_reg : count_reg + 1'b1;

    // Frame kind as seen from the ethertype collected so far.
    assign in_payload = (pos >= POS_HDR);
    assign is_v4      = in_payload && (ethertype_reg == ETYPE_IPV4);
    assign is_v6      = in_payload && (ethertype_reg == ETYPE_IPV6);
    assign is_arp     = in_payload && (ethertype_reg == ETYPE_ARP);

    // IPv4 layer-4 offset: the IHL byte itself counts at its own position.
    assign hdr      = (pos == POS_IHL) ? {in_byte[3:0], 2'b00} : ihl_reg;
    assign l4_start = 7'(ETH_HDR_BYTES) + {1'b0, hdr};
    assign l4_pos   = {{(LEN_WIDTH-7){1'b0}}, l4_start};
    assign port_off = pos - l4_pos;
    assign port_hit = (pos >= l4_pos) && (port_off < LEN_WIDTH'(4));

    // Byte placement by position.
    always_comb begin
        dst_mac_next   = dst_mac_reg;
        src_mac_next   = src_mac_reg;
        ethertype_next = ethertype_reg;
        ihl_next       = ihl_reg;
        proto_next     = proto_reg;
        src_hi_next    = src_hi_reg;
        src_lo_next    = src_lo_reg;
        dst_hi_next    = dst_hi_reg;
        dst_lo_next    = dst_lo_reg;
        ports_next     = ports_reg;

        // Ethernet header.
        for (int k = 0; k < 6; k++) begin
            if (pos == LEN_WIDTH'(5 - k)) dst_mac_next[8*k +: 8] = in_byte;
            if (pos == LEN_WIDTH'(11 - k)) src_mac_next[8*k +: 8] = in_byte;
        end
        for (int k = 0; k < 2; k++) begin
            if (pos == LEN_WIDTH'(13 - k)) ethertype_next[8*k +: 8] = in_byte;
        end

        // IPv4 header and layer-4 ports.
        if (is_v4) begin
            if (pos == POS_IHL) ihl_next = hdr;
            if (pos == POS_P4) proto_next = in_byte;
            for (int k = 0; k < 4; k++) begin
                if (pos == LEN_WIDTH'(29 - k)) src_lo_next[8*k +: 8] = in_byte;
                if (pos == LEN_WIDTH'(33 - k)) dst_lo_next[8*k +: 8] = in_byte;
            end
            if (port_hit) ports_next[8*(3 - port_off[1:0]) +: 8] = in_byte;
        end

        // IPv6 header and layer-4 ports.
        if (is_v6) begin
            if (pos == POS_P6) proto_next = in_byte;
            for (int k = 0; k < 8; k++) begin
                if (pos == LEN_WIDTH'(29 - k)) src_hi_next[8*k +: 8] = in_byte;
                if (pos == LEN_WIDTH'(37 - k)) src_lo_next[8*k +: 8] = in_byte;
                if (pos == LEN_WIDTH'(45 - k)) dst_hi_next[8*k +: 8] = in_byte;
                if (pos == LEN_WIDTH'(53 - k)) dst_lo_next[8*k +: 8] = in_byte;
            end
            for (int k = 0; k < 4; k++) begin
                if (pos == LEN_WIDTH'(57 - k)) ports_next[8*k +: 8] = in_byte;
            end
        end

        // ARP sender/target MACs replace the Ethernet MACs; their IPs fill src_lo/dst_lo.
        if (is_arp) begin
            for (int k = 0; k < 6; k++) begin
                if (pos == LEN_WIDTH'(27 - k)) src_mac_next[8*k +: 8] = in_byte;
                if (pos == LEN_WIDTH'(37 - k)) dst_mac_next[8*k +: 8] = in_byte;
            end
            for (int k = 0; k < 4; k++) begin
                if (pos == LEN_WIDTH'(31 - k)) src_lo_next[8*k +: 8] = in_byte;
                if (pos == LEN_WIDTH'(41 - k)) dst_lo_next[8*k +: 8] = in_byte;
            end
        end

        count_next = count_inc;
    end

    // The record register fills on a last byte and empties toward the output.
    assign rec_valid_next = (in_take && in_last) ? 1'b1 :
                            (rec_pop ? 1'b0 : rec_valid_reg);

    // Accumulators: updated per byte, cleared after each frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            dst_mac_reg   <= '0;
            src_mac_reg   <= '0;
            ethertype_reg <= '0;
            ihl_reg       <= '0;
            proto_reg     <= '0;
            src_hi_reg    <= '0;
            src_lo_reg    <= '0;
            dst_hi_reg    <= '0;
            dst_lo_reg    <= '0;
            ports_reg     <= '0;
            rec_valid_reg <= 1'b0;
        end else begin
            rec_valid_reg <= rec_valid_next;
            if (in_take) begin
                if (in_last) begin
                    count_reg     <= '0;
                    dst_mac_reg   <= '0;
                    src_mac_reg   <= '0;
                    ethertype_reg <= '0;
                    ihl_reg       <= '0;
                    proto_reg     <= '0;
                    src_hi_reg    <= '0;
                    src_lo_reg    <= '0;
                    dst_hi_reg    <= '0;
                    dst_lo_reg    <= '0;
                    ports_reg     <= '0;
                end else begin
                    count_reg     <= count_next;
                    dst_mac_reg   <= dst_mac_next;
                    src_mac_reg   <= src_mac_next;
                    ethertype_reg <= ethertype_next;
                    ihl_reg       <= ihl_next;
                    proto_reg     <= proto_next;
                    src_hi_reg    <= src_hi_next;
                    src_lo_reg    <= src_lo_next;
                    dst_hi_reg    <= dst_hi_next;
                    dst_lo_reg    <= dst_lo_next;
                    ports_reg     <= ports_next;
                end
            end
        end
    end

    // Frame record, loaded with the fields that include the last byte.
    always_ff @(posedge aclk) begin
        if (in_take && in_last) begin
            rec_reg.len       <= 16'(count_next);
            rec_reg.ethertype <= ethertype_next;
            rec_reg.ihl_bytes <= ihl_next;
            rec_reg.proto     <= proto_next;
            rec_reg.dst_mac   <= dst_mac_next;
            rec_reg.src_mac   <= src_mac_next;
            rec_reg.src_hi    <= src_hi_next;
            rec_reg.src_lo    <= src_lo_next;
            rec_reg.dst_hi    <= dst_hi_next;
            rec_reg.dst_lo    <= dst_lo_next;
            rec_reg.ports     <= ports_next;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

endmodule

// ===== rtl/ehfe_result.sv =====
// ----------------------------------------------------------------------------
// Ethernet header field extractor: result stage
// Classifies a finished frame record (kind, truncation, protocol check),
// masks the fields that do not apply and holds the result item in the output
// register until the sink takes it.
// ----------------------------------------------------------------------------
module ehfe_result (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rec_valid,
    input  ehfe_pkg::frame_rec_t rec,
    output logic                 rec_pop,
    output logic                 out_valid,
    output ehfe_pkg::result_t    out_item,
    input  logic                 out_ready
);
    import ehfe_pkg::*;

    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, res;
    logic [1:0] kind, status;
    logic       l4ok, known;
    logic [6:0] need, ihl_end;
    logic       pv;

    // The record moves on when the output register is empty or being read.
    assign rec_pop = rec_valid && (!out_valid_reg || out_ready);

    // Classification of the frame.
    always_comb begin
        kind    = (rec.len < 16'(ETH_HDR_BYTES)) ? KIND_OTHER : kind_of(rec.ethertype);
        l4ok    = (rec.proto == PROTO_TCP) || (rec.proto == PROTO_UDP);
        known   = l4ok || (rec.proto == PROTO_ICMP) || (rec.proto == PROTO_IGMP);
        ihl_end = 7'(ETH_HDR_BYTES + 4) + {1'b0, rec.ihl_bytes};
        status  = STATUS_OK;
        need    = 7'(ETH_HDR_BYTES);
        unique case (kind)
            KIND_IPV4: begin
                need = 7'd34;
                if (l4ok && (ihl_end > 7'd34)) need = ihl_end;
                if (!known) status = STATUS_UNKNOWN;
            end
            KIND_IPV6: begin
                need = l4ok ? 7'd58 : 7'd54;
            end
            KIND_ARP: begin
                need = 7'd42;
            end
            default: begin
                need = 7'(ETH_HDR_BYTES);
            end
        endcase
        if (rec.len < {9'b0, need}) status = STATUS_TRUNCATED;
        pv = ((kind == KIND_IPV4) || (kind == KIND_IPV6)) && l4ok && (status == STATUS_OK);

        res.frame_kind     = kind;
        res.status         = status;
        res.dest_mac       = rec.dst_mac;
        res.source_mac     = rec.src_mac;
        res.source_ip_high = (kind == KIND_OTHER) ? 64'd0 : rec.src_hi;
        res.source_ip_low  = (kind == KIND_OTHER) ? 64'd0 : rec.src_lo;
        res.dest_ip_high   = (kind == KIND_OTHER) ? 64'd0 : rec.dst_hi;
        res.dest_ip_low    = (kind == KIND_OTHER) ? 64'd0 : rec.dst_lo;
        res.source_port    = pv ? rec.ports[31:16] : 16'd0;
        res.dest_port      = pv ? rec.ports[15:0] : 16'd0;
        res.ports_valid    = pv;
        res.frame_length   = rec.len;
    end

    assign out_valid_next = rec_pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (rec_pop) begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== rtl/ehfe_checker.sv =====
// ----------------------------------------------------------------------------
// Ethernet header field extractor checker
// Watches the result channel of the top level and checks the consistency of
// each result item; attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module ehfe_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic [ehfe_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [ehfe_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready
);
    import ehfe_pkg::*;

    // A stalled result item holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // Only three status codes are ever produced.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[3:2] == STATUS_OK) || (m_tuser[3:2] == STATUS_UNKNOWN)
                     || (m_tuser[3:2] == STATUS_TRUNCATED))
        else $error("undefined status code");

    // Valid ports need an IP frame that arrived whole.
    a_ports_ip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[384] |->
            ((m_tuser[1:0] == KIND_IPV4) || (m_tuser[1:0] == KIND_IPV6))
            && (m_tuser[3:2] == STATUS_OK))
        else $error("ports flagged valid on a frame without usable ports");

    // Without valid ports both port fields read zero.
    a_ports_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[384] |-> (m_tdata[383:352] == 32'd0))
        else $error("port fields set while ports are not valid");

    // Frames of another kind carry no IP addresses.
    a_other_ip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == KIND_OTHER) |-> (m_tdata[351:96] == 256'd0))
        else $error("IP address fields set on a frame of another kind");

endmodule

bind ethernet_header_field_extractor ehfe_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
